@@ rtl/bhtm_pkg.sv @@
// Shared types, sizes and codes for the bucketed hash table map.
package bhtm_pkg;

  // Table geometry
  localparam int BUCKET_COUNT     = 10;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int VALUE_BITS       = 32;
  localparam int TOTAL_SLOTS      = BUCKET_COUNT * SLOTS_PER_BUCKET;

  // Field widths
  localparam int OP_BITS        = 2;
  localparam int KEY_BITS       = 31;
  localparam int IN_VALUE_BITS  = 32;
  localparam int STAT_BITS      = 3;
  localparam int OUT_VALUE_BITS = 32;

  // Stream packing, padded to whole bytes
  localparam int IN_DATA_W  = ((KEY_BITS + IN_VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_VALUE_BITS + 1 + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_DATA_W - KEY_BITS - IN_VALUE_BITS;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_VALUE_BITS - 1;

  // Derived index and counter widths
  localparam int ADDR_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int CNT_W   = $clog2(TOTAL_SLOTS + 1);

  // Reciprocal for key / BUCKET_COUNT: floor(key * MOD_MUL / 2^MOD_SHIFT) is exact
  // for every KEY_BITS-bit key
  localparam int              MOD_LOG   = $clog2(BUCKET_COUNT);
  localparam int              MOD_SHIFT = KEY_BITS + MOD_LOG;
  localparam int              MUL_W     = KEY_BITS + 1;
  localparam int              PROD_W    = KEY_BITS + MUL_W;
  localparam longint unsigned MOD_MUL   = ((64'd1 << MOD_SHIFT) / BUCKET_COUNT) + 64'd1;

  // Request kinds
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd2;

  // Result status codes
  localparam logic [STAT_BITS-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STAT_BITS-1:0] STAT_REPLACED = 3'd1;
  localparam logic [STAT_BITS-1:0] STAT_HIT      = 3'd2;
  localparam logic [STAT_BITS-1:0] STAT_MISS     = 3'd3;
  localparam logic [STAT_BITS-1:0] STAT_FULL     = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    IDLE,
    HASH,
    SCAN,
    ACT,
    VWAIT,
    RESP
  } state_t;

  // Modulo unit request and response
  typedef struct packed {
    logic                start;
    logic [KEY_BITS-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] rem;
  } mod_rsp_t;

endpackage

@@ rtl/bucketed_hash_table_map.sv @@
// Bucketed hash table map: 31-bit keys, value words, insert, remove and search.
// Each request goes from acceptance to its result through the states HASH, SCAN,
// ACT and RESP, and a search that hits also passes VWAIT to read the value
// memory; a three-stage reciprocal multiply picks the bucket as key modulo the
// bucket count, then the bucket's slots are read one per cycle through the single
// read port of the key memory, followed by the update in state ACT. One request is
// in flight at a time; s_axis_tready rises again once the previous result sits in
// the output register, so the next request may start while that result waits, and a
// result that still finds the output register full holds the sequencer until it
// drains. Valid bits live in flip-flops that reset clears at once, so no clearing
// pass follows reset.
module bucketed_hash_table_map import bhtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // lookup_key, entry_value, zero pad
  input  logic [OP_BITS-1:0]    s_axis_tuser,  // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found_value, table_empty, zero pad
  output logic [STAT_BITS-1:0]  m_axis_tuser   // status
);

  logic [KEY_BITS-1:0]       in_key;
  logic [IN_VALUE_BITS-1:0]  in_value;
  logic [OUT_VALUE_BITS-1:0] out_found;
  logic                      out_empty;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic                  key_we;
  logic [ADDR_W-1:0]     key_waddr;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [ADDR_W-1:0]     key_raddr;
  logic [KEY_BITS-1:0]   key_rdata;
  logic                  val_we;
  logic [ADDR_W-1:0]     val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [ADDR_W-1:0]     val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;

  // Stream unpacking and packing
  assign in_key       = s_axis_tdata[KEY_BITS-1:0];
  assign in_value     = s_axis_tdata[KEY_BITS +: IN_VALUE_BITS];
  assign m_axis_tdata = {OUT_PAD_W'(0), out_empty, out_found};

  bhtm_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  bhtm_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TOTAL_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  bhtm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TOTAL_SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  bhtm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_found  (out_found),
    .out_empty  (out_empty),
    .mod_req    (mod_req),
    .mod_rsp    (mod_rsp),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata),
    .val_we     (val_we),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .val_raddr  (val_raddr),
    .val_rdata  (val_rdata)
  );

endmodule

@@ rtl/bhtm_ram.sv @@
// Generic single write, single read RAM with registered read data.
module bhtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bhtm_mod_unit.sv @@
// Key modulo the bucket count by reciprocal multiplication, in three stages.
module bhtm_mod_unit import bhtm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                stage1;
  logic                stage2;
  logic                done;
  logic [KEY_BITS-1:0] key_q;
  logic [PROD_W-1:0]   prod;
  logic [BKT_W-1:0]    quot_lo;
  logic [BKT_W-1:0]    rem;

  // Remainder is below the bucket count, so the low quotient bits suffice
  assign quot_lo = prod[MOD_SHIFT +: BKT_W];

  // Control: key capture, product, remainder; done pulses once
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= req.start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      key_q <= req.dividend;
    end
    if (stage1) begin
      prod <= PROD_W'(key_q) * PROD_W'(MOD_MUL);
    end
    if (stage2) begin
      rem <= key_q[BKT_W-1:0] - BKT_W'(quot_lo * BKT_W'(BUCKET_COUNT));
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

@@ rtl/bhtm_ctrl.sv @@
// Request sequencer: bucket scan, slot update, valid bits and result register.
module bhtm_ctrl import bhtm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Request side
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_BITS-1:0]        in_op,
  input  logic [KEY_BITS-1:0]       in_key,
  input  logic [IN_VALUE_BITS-1:0]  in_value,
  // Result side
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STAT_BITS-1:0]      out_status,
  output logic [OUT_VALUE_BITS-1:0] out_found,
  output logic                      out_empty,
  // Modulo unit
  output mod_req_t                  mod_req,
  input  mod_rsp_t                  mod_rsp,
  // Key memory
  output logic                      key_we,
  output logic [ADDR_W-1:0]         key_waddr,
  output logic [KEY_BITS-1:0]       key_wdata,
  output logic [ADDR_W-1:0]         key_raddr,
  input  logic [KEY_BITS-1:0]       key_rdata,
  // Value memory
  output logic                      val_we,
  output logic [ADDR_W-1:0]         val_waddr,
  output logic [VALUE_BITS-1:0]     val_wdata,
  output logic [ADDR_W-1:0]         val_raddr,
  input  logic [VALUE_BITS-1:0]     val_rdata
);

  state_t state;
  state_t state_next;

  // Request registers
  logic [OP_BITS-1:0]        op;
  logic [KEY_BITS-1:0]       key;
  logic [VALUE_BITS-1:0]     value;
  logic [BKT_W-1:0]          bkt;

  // Scan registers
  logic [SLOT_CW-1:0]        issue;
  logic                      pend;
  logic [ADDR_W-1:0]         pend_addr;
  logic                      hit_f;
  logic [ADDR_W-1:0]         hit_addr;
  logic                      free_f;
  logic [ADDR_W-1:0]         free_addr;

  // Table occupancy
  logic [TOTAL_SLOTS-1:0]    valid;
  logic [CNT_W-1:0]          cnt;

  // Result before output register
  logic [STAT_BITS-1:0]      res_status;
  logic [OUT_VALUE_BITS-1:0] res_found;

  logic [ADDR_W-1:0]         base;
  logic [ADDR_W-1:0]         scan_addr;
  logic                      issuing;
  logic                      accept;
  logic                      load_out;
  logic                      match;

  assign base      = ADDR_W'(bkt) * ADDR_W'(SLOTS_PER_BUCKET);
  assign scan_addr = base + ADDR_W'(issue);
  assign issuing   = (issue != SLOT_CW'(SLOTS_PER_BUCKET));
  assign match     = valid[pend_addr] && (key_rdata == key);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == RESP) && (!out_valid || out_ready);

  // Next state and memory controls
  always_comb begin
    state_next = state;
    in_ready   = (state == IDLE);
    mod_req.start    = accept;
    mod_req.dividend = in_key;
    key_raddr  = scan_addr;
    val_raddr  = hit_addr;
    key_we     = 1'b0;
    key_waddr  = free_addr;
    key_wdata  = key;
    val_we     = 1'b0;
    val_waddr  = hit_f ? hit_addr : free_addr;
    val_wdata  = value;
    case (state)
      IDLE: begin
        if (in_valid) begin
          state_next = HASH;
        end
      end
      HASH: begin
        if (mod_rsp.done) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        if (!issuing && !pend) begin
          state_next = ACT;
        end
      end
      ACT: begin
        state_next = RESP;
        if (op == OP_INSERT) begin
          val_we = hit_f || free_f;
          key_we = !hit_f && free_f;
        end else if (op == OP_SEARCH && hit_f) begin
          state_next = VWAIT;
        end
      end
      VWAIT: begin
        state_next = RESP;
      end
      RESP: begin
        if (!out_valid || out_ready) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and bucket scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_op;
      key   <= in_key;
      value <= VALUE_BITS'(in_value);
    end
    if (state == HASH && mod_rsp.done) begin
      bkt    <= mod_rsp.rem;
      issue  <= '0;
      pend   <= 1'b0;
      hit_f  <= 1'b0;
      free_f <= 1'b0;
    end
    if (state == SCAN) begin
      pend      <= issuing;
      pend_addr <= scan_addr;
      if (issuing) begin
        issue <= issue + 1'b1;
      end
      if (pend) begin
        if (match && !hit_f) begin
          hit_f    <= 1'b1;
          hit_addr <= pend_addr;
        end
        if (!valid[pend_addr] && !free_f) begin
          free_f    <= 1'b1;
          free_addr <= pend_addr;
        end
      end
    end
  end

  // Valid bits and occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      cnt   <= '0;
    end else if (state == ACT) begin
      if (op == OP_INSERT && !hit_f && free_f) begin
        valid[free_addr] <= 1'b1;
        cnt              <= cnt + 1'b1;
      end else if (op == OP_REMOVE && hit_f) begin
        valid[hit_addr] <= 1'b0;
        cnt             <= cnt - 1'b1;
      end
    end
  end

  // Result selection
  always_ff @(posedge clk) begin
    if (state == ACT) begin
      res_found  <= '0;
      res_status <= STAT_MISS;
      case (op)
        OP_INSERT: begin
          if (hit_f) begin
            res_status <= STAT_REPLACED;
          end else if (free_f) begin
            res_status <= STAT_INSERTED;
          end else begin
            res_status <= STAT_FULL;
          end
        end
        OP_REMOVE, OP_SEARCH: begin
          if (hit_f) begin
            res_status <= STAT_HIT;
          end
        end
        default: begin
          res_status <= STAT_MISS;
        end
      endcase
    end
    if (state == VWAIT) begin
      res_found <= OUT_VALUE_BITS'(val_rdata);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_empty  <= (cnt == '0);
    end
  end

endmodule

@@ rtl/bhtm_checker.sv @@
// Port-level checks for the bucketed hash table map, bound to the top level.
module bhtm_checker import bhtm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,  // found_value, table_empty, zero pad
  input logic [STAT_BITS-1:0]  m_axis_tuser   // status
);

  // One request at a time: ready drops after each transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= STAT_FULL))
    else $error("undefined status code");

  // Found value is zero unless the status is a hit
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != STAT_HIT)) |->
      (m_axis_tdata[OUT_VALUE_BITS-1:0] == '0))
    else $error("found value set on a non-hit result");

  // A stored or replaced entry means the table is not empty
  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == STAT_INSERTED || m_axis_tuser == STAT_REPLACED))
      |-> !m_axis_tdata[OUT_VALUE_BITS])
    else $error("table reported empty after a store");

endmodule

bind bucketed_hash_table_map bhtm_checker u_bhtm_checker (.*);

@@ bench/bucketed_hash_table_map_tb.sv @@
// Testbench for the bucketed hash table map: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module bucketed_hash_table_map_tb;
  import bhtm_pkg::*;

  // Operation code with no meaning; the block answers it as a miss
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
  localparam int HIGH_KEY_BASE = 2147483630;  // top end of the key range, multiple of 10

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct {
    logic [STAT_BITS-1:0]      status;
    logic [OUT_VALUE_BITS-1:0] found_value;
    logic                      table_empty;
  } response_t;

  // Scoreboard: mirrors the table contents and holds the responses still owed
  class hash_map_scoreboard;
    key_t                 slot_key[TOTAL_SLOTS];
    logic [VALUE_BITS-1:0] slot_val[TOTAL_SLOTS];
    bit                   slot_used[TOTAL_SLOTS];
    response_t            pending_responses[$];
    int                   errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    // Update the mirror for one accepted request and queue its response
    function void apply_request(logic [OP_BITS-1:0] op, key_t key,
                                logic [IN_VALUE_BITS-1:0] value);
      int base;
      int hit;
      bit any_used;
      response_t rsp;
      base = (int'(key) % BUCKET_COUNT) * SLOTS_PER_BUCKET;
      hit = -1;
      rsp.status = STAT_MISS;
      rsp.found_value = '0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
        if (hit < 0 && slot_used[base + s] && slot_key[base + s] == key) hit = base + s;
      end
      case (op)
        OP_INSERT: begin
          if (hit >= 0) begin
            slot_val[hit] = VALUE_BITS'(value);
            rsp.status = STAT_REPLACED;
          end else begin
            rsp.status = STAT_FULL;
            // lowest free slot of the bucket
            for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
              if (rsp.status == STAT_FULL && !slot_used[base + s]) begin
                slot_used[base + s] = 1'b1;
                slot_key[base + s] = key;
                slot_val[base + s] = VALUE_BITS'(value);
                rsp.status = STAT_INSERTED;
              end
            end
          end
        end
        OP_REMOVE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            rsp.status = STAT_HIT;
          end
        end
        OP_SEARCH: begin
          if (hit >= 0) begin
            rsp.found_value = OUT_VALUE_BITS'(slot_val[hit]);
            rsp.status = STAT_HIT;
          end
        end
        default: ;
      endcase
      any_used = 1'b0;
      foreach (slot_used[i]) any_used |= slot_used[i];
      rsp.table_empty = !any_used;
      pending_responses.push_back(rsp);
    endfunction

    // Compare one accepted response with the oldest one owed
    function void check_response(logic [STAT_BITS-1:0] status,
                                 logic [OUT_VALUE_BITS-1:0] found_value,
                                 logic table_empty);
      response_t exp;
      if (pending_responses.size() == 0) begin
        $error("unexpected response: status %0d found_value 0x%08h table_empty %0d",
               status, found_value, table_empty);
        errors++;
        return;
      end
      exp = pending_responses.pop_front();
      if (status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (found_value !== exp.found_value) begin
        $error("found_value mismatch: expected 0x%08h, actual 0x%08h",
               exp.found_value, found_value);
        errors++;
      end
      if (table_empty !== exp.table_empty) begin
        $error("table_empty mismatch: expected %0d, actual %0d",
               exp.table_empty, table_empty);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_responses.size();
    endfunction

    // Keys currently stored, in slot order
    function void stored_keys(output key_t list[$]);
      list = {};
      foreach (slot_used[i]) if (slot_used[i]) list.push_back(slot_key[i]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_BITS-1:0]    s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_BITS-1:0]  m_axis_tuser;

  hash_map_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_requests;

  bucketed_hash_table_map u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Response transactions go to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_response(m_axis_tuser, m_axis_tdata[OUT_VALUE_BITS-1:0],
                        m_axis_tdata[OUT_VALUE_BITS]);
  end

  // Offer one request; entered and left just after a falling edge
  task automatic send_request(logic [OP_BITS-1:0] op, key_t key,
                              logic [IN_VALUE_BITS-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{IN_PAD_W{1'b0}}, value, key};
    do @(posedge clk); while (!s_axis_tready);
    sb.apply_request(op, key, value);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Keys mostly from a small pool per bucket, low and high end, so buckets fill up
  function automatic key_t pick_key();
    int r;
    int bucket;
    int k;
    r = $urandom_range(99);
    bucket = $urandom_range(BUCKET_COUNT - 1);
    k = $urandom_range(11);
    if (r < 5) return key_t'($urandom);
    if (r < 60) return key_t'(bucket + 10 * k);
    return key_t'(HIGH_KEY_BASE + bucket - 10 * k);
  endfunction

  task automatic random_requests(int count);
    int r;
    logic [OP_BITS-1:0] op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 40) op = OP_INSERT;
      else if (r < 70) op = OP_REMOVE;
      else if (r < 95) op = OP_SEARCH;
      else op = OP_UNUSED;
      send_request(op, pick_key(), $urandom);
    end
  endtask

  // Remove everything stored, with a few searches mixed in, down to an empty table
  task automatic drain_table();
    key_t keys[$];
    sb.stored_keys(keys);
    keys.shuffle();
    foreach (keys[i]) begin
      if ($urandom_range(9) == 0) send_request(OP_SEARCH, keys[i], $urandom);
      send_request(OP_REMOVE, keys[i], $urandom);
    end
    send_request(OP_SEARCH, keys.size() > 0 ? keys[0] : key_t'(0), $urandom);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_INSERT;
    hold_requests = 0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, key and value extremes, unused op
    send_request(OP_SEARCH, key_t'(0), 32'h0);
    send_request(OP_REMOVE, key_t'(0), 32'hFFFF_FFFF);
    send_request(OP_UNUSED, KEY_MAX, 32'hFFFF_FFFF);
    send_request(OP_INSERT, KEY_MAX, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, KEY_MAX, 32'h0);
    send_request(OP_INSERT, KEY_MAX, 32'h0);
    send_request(OP_SEARCH, KEY_MAX, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, KEY_MAX, 32'h0);
    // Fill one bucket, then one more key is refused
    for (int k = 0; k <= SLOTS_PER_BUCKET; k++)
      send_request(OP_INSERT, key_t'(3 + 10 * k), 32'hA5A5_0000 + k);
    send_request(OP_SEARCH, key_t'(3 + 10 * SLOTS_PER_BUCKET), 32'h0);
    send_request(OP_SEARCH, key_t'(73), 32'h0);
    // Freed slot is reused
    send_request(OP_REMOVE, key_t'(33), 32'h0);
    send_request(OP_INSERT, key_t'(3 + 10 * SLOTS_PER_BUCKET), 32'h5A5A_5A5A);
    send_request(OP_SEARCH, key_t'(3 + 10 * SLOTS_PER_BUCKET), 32'h0);
    send_request(OP_UNUSED, key_t'(13), 32'h1234_5678);
    send_request(OP_INSERT, key_t'(13), 32'h0);
    wait_drained();

    // Sender idles a little, receiver a lot
    src_idle_pct = 8;
    sink_idle_pct = 76;
    random_requests(380);
    drain_table();
    wait_drained();

    // Sender idles a lot, receiver a little
    src_idle_pct = 76;
    sink_idle_pct = 8;
    random_requests(380);
    drain_table();
    wait_drained();

    // No idling; receiver holds off for a long stretch while requests keep coming
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_requests++;
    random_requests(380);
    drain_table();
    wait_drained();

    repeat (60) @(negedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
